@@ rtl/core/rct_pkg.sv @@
// Shared types, codes and defaults for the reference-counted corner table.
package rct_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int DEFAULT_COUNT_BITS  = 16;

    localparam logic [7:0] FRAME_WIDTH_RESET = 8'd4;

    localparam logic [1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [2:0] ST_NEW         = 3'd0;
    localparam logic [2:0] ST_SHARED      = 3'd1;
    localparam logic [2:0] ST_DECREMENTED = 3'd2;
    localparam logic [2:0] ST_FREED       = 3'd3;
    localparam logic [2:0] ST_IGNORED     = 3'd4;
    localparam logic [2:0] ST_FULL        = 3'd5;
    localparam logic [2:0] ST_CLEARED     = 3'd6;

    typedef struct packed {
        logic        live;
        logic [16:0] x;
        logic [15:0] level;
        logic [16:0] z;
    } key_t;

    typedef struct packed {
        logic [8:0]  entry_id;
        logic [2:0]  status;
        logic [15:0] ref_count;
        logic [8:0]  live_count;
    } result_t;

endpackage

@@ rtl/core/refcounted_corner_table.sv @@
// Top level of the reference-counted corner table.
//
// A command beat is accepted at a rising edge where start is high and busy is low.
// The command is an acquire of a frame corner, a release of an entry id, or a clear.
// Each command gives exactly one result beat: done is high for one cycle while
// entry_id, status, ref_count and live_count hold the result. The receiver cannot
// stall; the result is taken in that cycle.
// An acquire searches the allocated slots of the entry memory in order, one slot per
// cycle; on a match it raises that count (saturating), else it takes the next unused
// slot or reports the table full. A release of an id within the allocated slots reads
// its entry from the entry memory; a clear, an unknown command or a release id out of
// range answers without reading the entry memory.
// A new command may be accepted in the cycle in which the result beat is shown.
// The frame width register is written with cfg_wr_en and cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset empties the table and sets the frame width to 4; no clearing pass is needed.
module refcounted_corner_table
    import rct_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int COUNT_BITS  = DEFAULT_COUNT_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic signed [15:0] anchor_x,
    input  logic signed [15:0] anchor_level,
    input  logic signed [15:0] anchor_z,
    input  logic [1:0]         corner_index,
    input  logic [15:0]        release_id,
    output logic               done,
    output logic [8:0]         entry_id,
    output logic [2:0]         status,
    output logic [15:0]        ref_count,
    output logic [8:0]         live_count
);

    localparam int SLOT_BITS = $clog2(TABLE_DEPTH);

    logic [7:0] frame_width_reg, frame_width_next;
    key_t       corner;
    result_t    result;

    logic                  mem_rd_en;
    logic [SLOT_BITS-1:0]  mem_rd_addr;
    key_t                  mem_rd_key;
    logic [COUNT_BITS-1:0] mem_rd_count;
    logic                  mem_wr_en;
    logic [SLOT_BITS-1:0]  mem_wr_addr;
    key_t                  mem_wr_key;
    logic [COUNT_BITS-1:0] mem_wr_count;

    assign frame_width_next = cfg_wr_en ? cfg_wr_data : frame_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RESET;
        end
        else
        begin
            frame_width_reg <= frame_width_next;
        end
    end

    // The corner is the anchor moved by the frame width on x and/or z.
    always_comb
    begin
        corner.live  = 1'b1;
        corner.x     = {anchor_x[15], anchor_x}
                     + (corner_index[0] ? {9'd0, frame_width_reg} : 17'd0);
        corner.level = anchor_level;
        corner.z     = {anchor_z[15], anchor_z}
                     + (corner_index[1] ? {9'd0, frame_width_reg} : 17'd0);
    end

    rct_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_BITS  (COUNT_BITS),
        .SLOT_BITS   (SLOT_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .corner       (corner),
        .release_id   (release_id),
        .done         (done),
        .result       (result),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_key   (mem_rd_key),
        .mem_rd_count (mem_rd_count),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_key   (mem_wr_key),
        .mem_wr_count (mem_wr_count)
    );

    rct_entry_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_BITS  (COUNT_BITS),
        .SLOT_BITS   (SLOT_BITS)
    ) u_entry_mem (
        .clk      (clk),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_key   (mem_rd_key),
        .rd_count (mem_rd_count),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_key   (mem_wr_key),
        .wr_count (mem_wr_count)
    );

    assign entry_id   = result.entry_id;
    assign status     = result.status;
    assign ref_count  = result.ref_count;
    assign live_count = result.live_count;

endmodule

@@ rtl/core/rct_entry_mem.sv @@
// Entry memory: corner key, live flag and reference count per slot, registered read.
module rct_entry_mem
    import rct_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int COUNT_BITS  = DEFAULT_COUNT_BITS,
    parameter int SLOT_BITS   = $clog2(TABLE_DEPTH)
)
(
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [SLOT_BITS-1:0]  rd_addr,
    output key_t                  rd_key,
    output logic [COUNT_BITS-1:0] rd_count,
    input  logic                  wr_en,
    input  logic [SLOT_BITS-1:0]  wr_addr,
    input  key_t                  wr_key,
    input  logic [COUNT_BITS-1:0] wr_count
);

    key_t                  key_mem [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] count_mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= wr_key;
            count_mem[wr_addr] <= wr_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key   <= key_mem[rd_addr];
            rd_count <= count_mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/rct_engine.sv @@
// Command sequencer: scans, allocates, releases and clears entries in the entry memory.
module rct_engine
    import rct_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int COUNT_BITS  = DEFAULT_COUNT_BITS,
    parameter int SLOT_BITS   = $clog2(TABLE_DEPTH)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            cmd,
    input  key_t                  corner,
    input  logic [15:0]           release_id,
    output logic                  done,
    output result_t               result,
    output logic                  mem_rd_en,
    output logic [SLOT_BITS-1:0]  mem_rd_addr,
    input  key_t                  mem_rd_key,
    input  logic [COUNT_BITS-1:0] mem_rd_count,
    output logic                  mem_wr_en,
    output logic [SLOT_BITS-1:0]  mem_wr_addr,
    output key_t                  mem_wr_key,
    output logic [COUNT_BITS-1:0] mem_wr_count
);

    localparam int NSW = SLOT_BITS + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_ALLOC = 2'd2;
    localparam logic [1:0] S_REL   = 2'd3;

    logic [1:0]           state_reg, state_next;
    key_t                 key_reg, key_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [NSW-1:0]       next_slot_reg, next_slot_next;
    logic [NSW-1:0]       live_total_reg, live_total_next;
    logic                 done_reg, done_next;
    result_t              result_reg, result_next;

    logic [NSW-1:0]        slot_plus1;
    logic [15:0]           id_minus1;
    logic                  id_valid;
    logic                  key_hit;
    logic [COUNT_BITS-1:0] count_inc;
    logic [COUNT_BITS-1:0] count_dec;

    assign slot_plus1 = NSW'(slot_reg) + NSW'(1);
    assign id_minus1  = release_id - 16'd1;
    assign id_valid   = (release_id != 16'd0) && (32'(release_id) <= 32'(next_slot_reg));
    assign key_hit    = (mem_rd_key == key_reg);
    assign count_inc  = (mem_rd_count == '1) ? mem_rd_count : mem_rd_count + COUNT_BITS'(1);
    assign count_dec  = mem_rd_count - COUNT_BITS'(1);

    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        slot_next       = slot_reg;
        next_slot_next  = next_slot_reg;
        live_total_next = live_total_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = slot_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = slot_reg;
        mem_wr_key      = mem_rd_key;
        mem_wr_count    = mem_rd_count;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_ACQUIRE:
                        begin
                            key_next      = corner;
                            key_next.live = 1'b1;
                            if (next_slot_reg != '0)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = '0;
                                slot_next   = '0;
                                state_next  = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_ALLOC;
                            end
                        end
                        CMD_RELEASE:
                        begin
                            if (id_valid)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = SLOT_BITS'(id_minus1);
                                slot_next   = SLOT_BITS'(id_minus1);
                                state_next  = S_REL;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '{9'd0, ST_IGNORED, 16'd0, 9'(live_total_reg)};
                            end
                        end
                        CMD_CLEAR:
                        begin
                            next_slot_next  = '0;
                            live_total_next = '0;
                            done_next       = 1'b1;
                            result_next     = '{9'd0, ST_CLEARED, 16'd0, 9'd0};
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{9'd0, ST_IGNORED, 16'd0, 9'(live_total_reg)};
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (key_hit)
                begin
                    mem_wr_en    = 1'b1;
                    mem_wr_count = count_inc;
                    done_next    = 1'b1;
                    result_next  = '{9'(slot_plus1), ST_SHARED, 16'(count_inc),
                                     9'(live_total_reg)};
                    state_next   = S_IDLE;
                end
                else if (slot_plus1 < next_slot_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = slot_plus1[SLOT_BITS-1:0];
                    slot_next   = slot_plus1[SLOT_BITS-1:0];
                end
                else
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (next_slot_reg == NSW'(TABLE_DEPTH))
                begin
                    result_next = '{9'd0, ST_FULL, 16'd0, 9'(live_total_reg)};
                end
                else
                begin
                    mem_wr_en       = 1'b1;
                    mem_wr_addr     = next_slot_reg[SLOT_BITS-1:0];
                    mem_wr_key      = key_reg;
                    mem_wr_count    = COUNT_BITS'(1);
                    next_slot_next  = next_slot_reg + NSW'(1);
                    live_total_next = live_total_reg + NSW'(1);
                    result_next     = '{9'(next_slot_reg + NSW'(1)), ST_NEW, 16'd1,
                                        9'(live_total_reg + NSW'(1))};
                end
            end
            S_REL:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (!mem_rd_key.live)
                begin
                    result_next = '{9'd0, ST_IGNORED, 16'd0, 9'(live_total_reg)};
                end
                else if (mem_rd_count > COUNT_BITS'(1))
                begin
                    mem_wr_en    = 1'b1;
                    mem_wr_count = count_dec;
                    result_next  = '{9'(slot_plus1), ST_DECREMENTED, 16'(count_dec),
                                     9'(live_total_reg)};
                end
                else
                begin
                    mem_wr_en       = 1'b1;
                    mem_wr_key.live = 1'b0;
                    mem_wr_count    = '0;
                    live_total_next = live_total_reg - NSW'(1);
                    result_next     = '{9'(slot_plus1), ST_FREED, 16'd0,
                                        9'(live_total_reg - NSW'(1))};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            next_slot_reg  <= '0;
            live_total_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_slot_reg  <= next_slot_next;
            live_total_reg <= live_total_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        slot_reg   <= slot_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_live_within_used: assert property (@(posedge clk) disable iff (!rst_n)
        live_total_reg <= next_slot_reg)
        else $error("live entry total exceeds allocated slots");

    a_used_within_depth: assert property (@(posedge clk) disable iff (!rst_n)
        next_slot_reg <= NSW'(TABLE_DEPTH))
        else $error("allocated slot count exceeds table depth");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result beat while a command is still in progress");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_CLEAR) |=>
            (done_reg && result_reg.status == ST_CLEARED && next_slot_reg == '0))
        else $error("clear command did not empty the table in one cycle");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> NSW'(mem_wr_addr) <= next_slot_reg)
        else $error("entry write beyond the allocated slots");
`endif

endmodule

@@ tb/sv/refcounted_corner_table_tb.sv @@
// Self-checking testbench for the reference-counted corner table.
`timescale 1ns / 100ps

module refcounted_corner_table_tb;
    import rct_pkg::*;

    localparam int          DEPTH       = DEFAULT_TABLE_DEPTH;
    localparam logic [15:0] REFS_MAX    = 16'hFFFF;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          DIR_ROWS    = 18;
    localparam int          PHASES      = 5;
    localparam int          PHASE_BEATS = 94;
    localparam int          CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] ax;
        logic [15:0] al;
        logic [15:0] az;
        logic [1:0]  ci;
        logic [15:0] rid;
    } corner_cmd_t;

    typedef struct packed {
        corner_cmd_t c;
        logic        chk;
        result_t     res;
    } dir_row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [7:0]  cfg_wr_data  = 8'd0;
    logic        start        = 1'b0;
    logic        busy;
    logic [1:0]  cmd          = CMD_ACQUIRE;
    logic [15:0] anchor_x     = 16'd0;
    logic [15:0] anchor_level = 16'd0;
    logic [15:0] anchor_z     = 16'd0;
    logic [1:0]  corner_index = 2'd0;
    logic [15:0] release_id   = 16'd0;
    logic        done;
    logic [8:0]  entry_id;
    logic [2:0]  status;
    logic [15:0] ref_count;
    logic [8:0]  live_count;

    logic [16:0] tbl_x     [DEPTH];
    logic [15:0] tbl_level [DEPTH];
    logic [16:0] tbl_z     [DEPTH];
    logic [15:0] tbl_refs  [DEPTH];
    logic        tbl_live  [DEPTH];
    int          alloc_ptr;
    int          live_entries;
    logic [7:0]  width_reg;

    result_t     pending_replies[$];
    int          mismatch_cnt = 0;
    int          cycle_cnt    = 0;
    int          burst_left   = 0;
    dir_row_t    dir_rows [DIR_ROWS];

    refcounted_corner_table u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .anchor_x     (anchor_x),
        .anchor_level (anchor_level),
        .anchor_z     (anchor_z),
        .corner_index (corner_index),
        .release_id   (release_id),
        .done         (done),
        .entry_id     (entry_id),
        .status       (status),
        .ref_count    (ref_count),
        .live_count   (live_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void wipe_table();
        for (int s = 0; s < DEPTH; s++)
        begin
            tbl_live[s] = 1'b0;
        end
        alloc_ptr    = 0;
        live_entries = 0;
    endfunction

    function automatic result_t apply_to_table(corner_cmd_t c);
        logic [16:0] cx;
        logic [16:0] cz;
        int          found;
        int          id;
        result_t     r;
        r.entry_id  = '0;
        r.status    = ST_IGNORED;
        r.ref_count = '0;
        case (c.op)
            CMD_ACQUIRE:
            begin
                cx = {c.ax[15], c.ax} + (c.ci[0] ? {9'd0, width_reg} : 17'd0);
                cz = {c.az[15], c.az} + (c.ci[1] ? {9'd0, width_reg} : 17'd0);
                found = -1;
                for (int s = 0; s < alloc_ptr && found < 0; s++)
                begin
                    if (tbl_live[s] && tbl_x[s] == cx && tbl_level[s] == c.al &&
                        tbl_z[s] == cz)
                    begin
                        found = s;
                    end
                end
                if (found >= 0)
                begin
                    if (tbl_refs[found] != REFS_MAX)
                    begin
                        tbl_refs[found]++;
                    end
                    r.entry_id  = 9'(found + 1);
                    r.status    = ST_SHARED;
                    r.ref_count = tbl_refs[found];
                end
                else if (alloc_ptr >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    tbl_x[alloc_ptr]     = cx;
                    tbl_level[alloc_ptr] = c.al;
                    tbl_z[alloc_ptr]     = cz;
                    tbl_refs[alloc_ptr]  = 16'd1;
                    tbl_live[alloc_ptr]  = 1'b1;
                    alloc_ptr++;
                    live_entries++;
                    r.entry_id  = 9'(alloc_ptr);
                    r.status    = ST_NEW;
                    r.ref_count = 16'd1;
                end
            end
            CMD_RELEASE:
            begin
                id = int'(c.rid);
                if (!(id == 0 || id > alloc_ptr || !tbl_live[id - 1]))
                begin
                    r.entry_id = 9'(id);
                    if (tbl_refs[id - 1] > 16'd1)
                    begin
                        tbl_refs[id - 1]--;
                        r.status    = ST_DECREMENTED;
                        r.ref_count = tbl_refs[id - 1];
                    end
                    else
                    begin
                        tbl_refs[id - 1] = 16'd0;
                        tbl_live[id - 1] = 1'b0;
                        live_entries--;
                        r.status = ST_FREED;
                    end
                end
            end
            CMD_CLEAR:
            begin
                wipe_table();
                r.status = ST_CLEARED;
            end
            default:
            begin
                r.status = ST_IGNORED;
            end
        endcase
        r.live_count = 9'(live_entries);
        return r;
    endfunction

    function automatic corner_cmd_t mk_cmd(logic [1:0] op, logic [15:0] ax, logic [15:0] al,
                                           logic [15:0] az, logic [1:0] ci, logic [15:0] rid);
        corner_cmd_t c;
        c.op  = op;
        c.ax  = ax;
        c.al  = al;
        c.az  = az;
        c.ci  = ci;
        c.rid = rid;
        return c;
    endfunction

    function automatic dir_row_t dir_row(corner_cmd_t c, logic chk, logic [8:0] id,
                                         logic [2:0] st, logic [15:0] refs, logic [8:0] live);
        dir_row_t row;
        row.c              = c;
        row.chk            = chk;
        row.res.entry_id   = id;
        row.res.status     = st;
        row.res.ref_count  = refs;
        row.res.live_count = live;
        return row;
    endfunction

    // Most acquires land on a small lattice of frames so that corners are shared.
    function automatic corner_cmd_t random_cmd();
        corner_cmd_t c;
        int          pick;
        c.ax  = 16'($urandom);
        c.al  = 16'($urandom);
        c.az  = 16'($urandom);
        c.ci  = 2'($urandom);
        c.rid = 16'($urandom);
        pick  = $urandom_range(0, 99);
        if (pick < 50)
        begin
            c.op = CMD_ACQUIRE;
            if ($urandom_range(0, 3) != 0)
            begin
                c.ax = 16'((int'($urandom_range(0, 2)) - 1) * int'(width_reg));
                c.az = 16'((int'($urandom_range(0, 2)) - 1) * int'(width_reg));
                c.al = 16'($urandom_range(0, 1));
            end
        end
        else if (pick < 88)
        begin
            c.op = CMD_RELEASE;
            if (alloc_ptr > 0 && $urandom_range(0, 4) != 0)
            begin
                c.rid = 16'($urandom_range(1, alloc_ptr));
            end
            else if ($urandom_range(0, 1) == 1)
            begin
                c.rid = 16'($urandom_range(0, alloc_ptr + 2));
            end
        end
        else if (pick < 97)
        begin
            c.op = CMD_ACQUIRE;
        end
        else if (pick < 99)
        begin
            c.op = CMD_UNUSED;
        end
        else
        begin
            c.op = CMD_CLEAR;
        end
        return c;
    endfunction

    // The sender runs in bursts; a gap may follow each burst.
    task automatic send_cmd(input corner_cmd_t c, input logic use_typed, input result_t typed);
        int      gap;
        result_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100)
                                                     : $urandom_range(1, 16);
        end
        cmd          <= c.op;
        anchor_x     <= c.ax;
        anchor_level <= c.al;
        anchor_z     <= c.az;
        corner_index <= c.ci;
        release_id   <= c.rid;
        start        <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predicted = apply_to_table(c);
        pending_replies = {pending_replies, (use_typed ? typed : predicted)};
        burst_left--;
    endtask

    task automatic drain_results();
        start      <= 1'b0;
        burst_left = 0;
        while (pending_replies.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_frame_width(input logic [7:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        width_reg   = value;
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                begin
                    $display("%0t: unexpected result beat id=%0d st=%0d refs=%0d live=%0d",
                             $realtime, entry_id, status, ref_count, live_count);
                end
            end
            else
            begin
                want = pending_replies.pop_front();
                if (entry_id !== want.entry_id || status !== want.status ||
                    ref_count !== want.ref_count || live_count !== want.live_count)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("%0t: expected id=%0d st=%0d refs=%0d live=%0d",
                                 $realtime, want.entry_id, want.status, want.ref_count,
                                 want.live_count);
                        $display("    got id=%0d st=%0d refs=%0d live=%0d",
                                 entry_id, status, ref_count, live_count);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] phase_width [PHASES];
        result_t    no_result;
        no_result = '0;
        width_reg = FRAME_WIDTH_RESET;
        wipe_table();

        phase_width[0] = 8'd1;
        phase_width[1] = 8'd255;
        phase_width[2] = 8'd0;
        phase_width[3] = 8'($urandom_range(2, 254));
        phase_width[4] = FRAME_WIDTH_RESET;

        dir_rows[0]  = dir_row(mk_cmd(CMD_RELEASE, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'd0),
                               1'b1, 9'd0, ST_IGNORED, 16'd0, 9'd0);
        dir_rows[1]  = dir_row(mk_cmd(CMD_UNUSED, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'd1),
                               1'b1, 9'd0, ST_IGNORED, 16'd0, 9'd0);
        dir_rows[2]  = dir_row(mk_cmd(CMD_ACQUIRE, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'd0),
                               1'b1, 9'd1, ST_NEW, 16'd1, 9'd1);
        dir_rows[3]  = dir_row(mk_cmd(CMD_ACQUIRE, 16'hFFFC, 16'h0000, 16'h0000, 2'd1, 16'd0),
                               1'b1, 9'd1, ST_SHARED, 16'd2, 9'd1);
        dir_rows[4]  = dir_row(mk_cmd(CMD_ACQUIRE, 16'h0000, 16'h0000, 16'hFFFC, 2'd2, 16'd0),
                               1'b1, 9'd1, ST_SHARED, 16'd3, 9'd1);
        dir_rows[5]  = dir_row(mk_cmd(CMD_ACQUIRE, 16'hFFFC, 16'h0000, 16'hFFFC, 2'd3, 16'd0),
                               1'b0, 9'd0, ST_NEW, 16'd0, 9'd0);
        dir_rows[6]  = dir_row(mk_cmd(CMD_ACQUIRE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 2'd3, 16'd0),
                               1'b1, 9'd2, ST_NEW, 16'd1, 9'd2);
        dir_rows[7]  = dir_row(mk_cmd(CMD_ACQUIRE, 16'h8000, 16'h8000, 16'h8000, 2'd0, 16'd0),
                               1'b1, 9'd3, ST_NEW, 16'd1, 9'd3);
        dir_rows[8]  = dir_row(mk_cmd(CMD_ACQUIRE, 16'h7FFF, 16'h8000, 16'h7FFF, 2'd0, 16'd0),
                               1'b1, 9'd4, ST_NEW, 16'd1, 9'd4);
        dir_rows[9]  = dir_row(mk_cmd(CMD_RELEASE, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'd1),
                               1'b0, 9'd0, ST_NEW, 16'd0, 9'd0);
        dir_rows[10] = dir_row(mk_cmd(CMD_RELEASE, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'd2),
                               1'b1, 9'd2, ST_FREED, 16'd0, 9'd3);
        dir_rows[11] = dir_row(mk_cmd(CMD_RELEASE, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'd2),
                               1'b1, 9'd0, ST_IGNORED, 16'd0, 9'd3);
        dir_rows[12] = dir_row(mk_cmd(CMD_RELEASE, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'd5),
                               1'b1, 9'd0, ST_IGNORED, 16'd0, 9'd3);
        dir_rows[13] = dir_row(mk_cmd(CMD_RELEASE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3,
                                      16'hFFFF), 1'b1, 9'd0, ST_IGNORED, 16'd0, 9'd3);
        dir_rows[14] = dir_row(mk_cmd(CMD_ACQUIRE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 2'd3, 16'd0),
                               1'b0, 9'd0, ST_NEW, 16'd0, 9'd0);
        dir_rows[15] = dir_row(mk_cmd(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'd0),
                               1'b1, 9'd0, ST_CLEARED, 16'd0, 9'd0);
        dir_rows[16] = dir_row(mk_cmd(CMD_ACQUIRE, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'd0),
                               1'b1, 9'd1, ST_NEW, 16'd1, 9'd1);
        dir_rows[17] = dir_row(mk_cmd(CMD_RELEASE, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'd1),
                               1'b1, 9'd1, ST_FREED, 16'd0, 9'd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_cmd(dir_rows[i].c, dir_rows[i].chk, dir_rows[i].res);
        end

        // Fill every slot, then probe the full table with new, shared and freed corners.
        send_cmd(mk_cmd(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'd0), 1'b0, no_result);
        for (int i = 0; i < DEPTH; i++)
        begin
            send_cmd(mk_cmd(CMD_ACQUIRE, 16'(i), 16'h1234, 16'h0000, 2'd0, 16'd0),
                     1'b0, no_result);
        end
        send_cmd(mk_cmd(CMD_ACQUIRE, 16'd1000, 16'h1234, 16'h0000, 2'd0, 16'd0),
                 1'b0, no_result);
        send_cmd(mk_cmd(CMD_ACQUIRE, 16'd5, 16'h1234, 16'h0000, 2'd0, 16'd0), 1'b0, no_result);
        send_cmd(mk_cmd(CMD_RELEASE, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'(DEPTH)),
                 1'b0, no_result);
        send_cmd(mk_cmd(CMD_ACQUIRE, 16'(DEPTH - 1), 16'h1234, 16'h0000, 2'd0, 16'd0),
                 1'b0, no_result);
        send_cmd(mk_cmd(CMD_RELEASE, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'(DEPTH + 1)),
                 1'b0, no_result);

        send_cmd(mk_cmd(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'd0), 1'b0, no_result);

        for (int p = 0; p < PHASES; p++)
        begin
            set_frame_width(phase_width[p]);
            repeat (PHASE_BEATS)
            begin
                send_cmd(random_cmd(), 1'b0, no_result);
            end
        end

        drain_results();
        repeat (DEPTH + 8) @(posedge clk);
        if (mismatch_cnt == 0 && pending_replies.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
